[src/mms_pkg.sv]
// ----------------------------------------------------------------------------
// mms_pkg
// Shared types and codes of the min/max tracking stack.
// ----------------------------------------------------------------------------
package mms_pkg;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

endpackage

[src/mms_if.sv]
// ----------------------------------------------------------------------------
// mms_in_if / mms_out_if
// Valid/ready channels carrying stack operations and stack results.
// ----------------------------------------------------------------------------
interface mms_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic signed [VALUE_WIDTH-1:0] push_value;

  modport source (output valid, output operation, output push_value, input ready);
  modport sink   (input valid, input operation, input push_value, output ready);
endinterface

interface mms_out_if #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 7
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] popped_value;
  logic signed [VALUE_WIDTH-1:0] min_value;
  logic signed [VALUE_WIDTH-1:0] max_value;
  logic [COUNT_WIDTH-1:0]        entry_count;
  logic                          is_empty;
  mms_pkg::status_e              status;

  modport source (output valid, output popped_value, output min_value, output max_value,
                  output entry_count, output is_empty, output status, input ready);
  modport sink   (input valid, input popped_value, input min_value, input max_value,
                  input entry_count, input is_empty, input status, output ready);
endinterface

[src/mms_ram.sv]
// ----------------------------------------------------------------------------
// mms_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[src/min_max_tracking_stack.sv]
// ----------------------------------------------------------------------------
// min_max_tracking_stack
// Bounded LIFO of signed words reporting the running minimum and maximum.
// ----------------------------------------------------------------------------
//  channel   direction  transaction
//  in_i      sink       operation (push/pop) and push_value
//  out_o     source     popped_value, min_value, max_value, entry_count,
//                       is_empty, status
//
//  For a push, overflow or underflow the accepting cycle writes the result
//  register. A pop reads the top entry's value and link from the RAMs,
//  then the linked entry's value, then updates the state.
//  Reset clears count, extreme indexes and caches; the RAMs need no clearing.
//  A full result register stalls acceptance or holds the pop's final step.
module min_max_tracking_stack #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mms_in_if.sink   in_i,
  mms_out_if.source out_o
);
  import mms_pkg::*;

  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE     = 3'b001,
    S_POP_TOP  = 3'b010,
    S_POP_BACK = 3'b100
  } state_e;

  state_e                        state_q, state_d;
  logic [COUNT_W-1:0]            count_q, count_d;
  logic [IDX_W-1:0]              min_idx_q, min_idx_d, max_idx_q, max_idx_d;
  logic signed [VALUE_WIDTH-1:0] min_val_q, min_val_d, max_val_q, max_val_d;
  logic signed [VALUE_WIDTH-1:0] top_val_q, top_val_d;
  logic [IDX_W-1:0]              top_link_q, top_link_d;

  logic                          out_valid_q, out_valid_d;
  logic signed [VALUE_WIDTH-1:0] popped_q, popped_d, omin_q, omin_d, omax_q, omax_d;
  logic [COUNT_W-1:0]            ocount_q, ocount_d;
  logic                          oempty_q, oempty_d;
  status_e                       ostatus_q, ostatus_d;

  logic                          out_free, in_acc, load;
  logic                          is_full, is_empty_now;
  logic [COUNT_W-1:0]            count_dec;
  logic [IDX_W-1:0]              top_idx, slot;
  logic                          we;
  logic [IDX_W-1:0]              wlink, raddr;
  logic [VALUE_WIDTH-1:0]        val_rdata;
  logic [IDX_W-1:0]              link_rdata;
  logic signed [VALUE_WIDTH-1:0] back_val;

  assign out_free     = !out_valid_q || out_o.ready;
  assign in_i.ready   = (state_q == S_IDLE) && out_free;
  assign in_acc       = in_i.valid && in_i.ready;
  assign is_full      = (count_q == COUNT_W'(STACK_DEPTH));
  assign is_empty_now = (count_q == '0);
  assign count_dec    = count_q - COUNT_W'(1);
  assign top_idx      = count_dec[IDX_W-1:0];
  assign slot         = count_q[IDX_W-1:0];
  assign back_val     = $signed(val_rdata);

  always_comb begin
    case (state_q)
      S_POP_TOP:  raddr = link_rdata;
      S_POP_BACK: raddr = top_link_q;
      default:    raddr = top_idx;
    endcase
  end

  mms_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(STACK_DEPTH)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot),
    .wdata_i (in_i.push_value),
    .raddr_i (raddr),
    .rdata_o (val_rdata)
  );

  mms_ram #(.WIDTH(IDX_W), .DEPTH(STACK_DEPTH)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (slot),
    .wdata_i (wlink),
    .raddr_i (raddr),
    .rdata_o (link_rdata)
  );

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    min_idx_d  = min_idx_q;
    max_idx_d  = max_idx_q;
    min_val_d  = min_val_q;
    max_val_d  = max_val_q;
    top_val_d  = top_val_q;
    top_link_d = top_link_q;
    we         = 1'b0;
    wlink      = '0;
    load       = 1'b0;
    popped_d   = '0;
    ostatus_d  = STATUS_OK;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.operation == OP_PUSH) begin
            load = 1'b1;
            if (is_full) begin
              ostatus_d = STATUS_OVERFLOW;
            end else begin
              we      = 1'b1;
              count_d = count_q + COUNT_W'(1);
              if (is_empty_now) begin
                min_idx_d = slot;
                max_idx_d = slot;
                min_val_d = in_i.push_value;
                max_val_d = in_i.push_value;
              end else if (in_i.push_value < min_val_q) begin
                wlink     = min_idx_q;
                min_idx_d = slot;
                min_val_d = in_i.push_value;
              end else if (in_i.push_value > max_val_q) begin
                wlink     = max_idx_q;
                max_idx_d = slot;
                max_val_d = in_i.push_value;
              end
            end
          end else if (is_empty_now) begin
            load      = 1'b1;
            ostatus_d = STATUS_UNDERFLOW;
          end else begin
            state_d = S_POP_TOP;
          end
        end
      end
      S_POP_TOP: begin
        top_val_d  = $signed(val_rdata);
        top_link_d = link_rdata;
        state_d    = S_POP_BACK;
      end
      S_POP_BACK: begin
        // hold here until the result register frees up
        if (out_free) begin
          load     = 1'b1;
          popped_d = top_val_q;
          count_d  = count_dec;
          if (top_idx == min_idx_q) begin
            min_idx_d = top_link_q;
            min_val_d = back_val;
          end
          if (top_idx == max_idx_q) begin
            max_idx_d = top_link_q;
            max_val_d = back_val;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    oempty_d = (count_d == '0);
    ocount_d = count_d;
    omin_d   = oempty_d ? '0 : min_val_d;
    omax_d   = oempty_d ? '0 : max_val_d;
  end

  assign out_valid_d = load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      min_idx_q   <= '0;
      max_idx_q   <= '0;
      min_val_q   <= '0;
      max_val_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      min_idx_q   <= min_idx_d;
      max_idx_q   <= max_idx_d;
      min_val_q   <= min_val_d;
      max_val_q   <= max_val_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_val_q  <= top_val_d;
    top_link_q <= top_link_d;
    if (load) begin
      popped_q  <= popped_d;
      omin_q    <= omin_d;
      omax_q    <= omax_d;
      ocount_q  <= ocount_d;
      oempty_q  <= oempty_d;
      ostatus_q <= ostatus_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.popped_value = popped_q;
  assign out_o.min_value    = omin_q;
  assign out_o.max_value    = omax_q;
  assign out_o.entry_count  = ocount_q;
  assign out_o.is_empty     = oempty_q;
  assign out_o.status       = ostatus_q;

endmodule

[src/mms_checker.sv]
// ----------------------------------------------------------------------------
// mms_checker
// Port-level checks of the min/max tracking stack, bound to its top level.
// ----------------------------------------------------------------------------
module mms_checker #(
  parameter int STACK_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   out_valid_i,
  input logic                                   out_ready_i,
  input logic signed [VALUE_WIDTH-1:0]          popped_value_i,
  input logic signed [VALUE_WIDTH-1:0]          min_value_i,
  input logic signed [VALUE_WIDTH-1:0]          max_value_i,
  input logic [$clog2(STACK_DEPTH+1)-1:0]       entry_count_i,
  input logic                                   is_empty_i,
  input mms_pkg::status_e                       status_i
);
  import mms_pkg::*;

  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

  // empty flag, count and zeroed extremes agree
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_empty_i == (entry_count_i == '0)) &&
                    (!is_empty_i || (min_value_i == '0 && max_value_i == '0)))
    else $error("empty flag inconsistent with count or extremes");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_OVERFLOW |-> entry_count_i == COUNT_W'(STACK_DEPTH))
    else $error("overflow reported while not full");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STATUS_OK |-> popped_value_i == '0)
    else $error("failed operation returned a popped value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(entry_count_i) &&
                                    $stable(status_i))
    else $error("stalled result dropped or changed");

endmodule

bind min_max_tracking_stack mms_checker #(
  .STACK_DEPTH (STACK_DEPTH),
  .VALUE_WIDTH (VALUE_WIDTH)
) u_mms_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .popped_value_i (out_o.popped_value),
  .min_value_i    (out_o.min_value),
  .max_value_i    (out_o.max_value),
  .entry_count_i  (out_o.entry_count),
  .is_empty_i     (out_o.is_empty),
  .status_i       (out_o.status)
);
